FILE: rtl/dsd_pkg.sv
// Package of types, constants and helper functions for the dual stick direction decoder.
`default_nettype none
package dsd_pkg;

  localparam int unsigned FracBits = 8;
  localparam int unsigned NormW    = FracBits + 2;
  localparam int unsigned SqW      = 2 * FracBits + 1;
  localparam int unsigned SumW     = SqW + 1;
  localparam int unsigned AxisW    = 6;
  localparam int unsigned DivHi    = FracBits / 2;
  localparam int unsigned DivLo    = FracBits - DivHi;
  localparam int unsigned CfgW     = 18;

  typedef enum logic [2:0] {
    CfgLeftX   = 3'd0,
    CfgLeftY   = 3'd1,
    CfgRightX  = 3'd2,
    CfgRightY  = 3'd3,
    CfgDzSel   = 3'd4,
    CfgWayMode = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    Way8 = 2'd0,
    Way4 = 2'd1,
    Way2 = 2'd2
  } way_e;

  // Squared dead zone radius, rounded up: (k^2 << 2F) / 10000.
  localparam logic [SumW-1:0] DzThresh [8] = '{
    SumW'(((64'd144  << (2 * FracBits)) + 64'd9999) / 64'd10000),
    SumW'(((64'd225  << (2 * FracBits)) + 64'd9999) / 64'd10000),
    SumW'(((64'd289  << (2 * FracBits)) + 64'd9999) / 64'd10000),
    SumW'(((64'd400  << (2 * FracBits)) + 64'd9999) / 64'd10000),
    SumW'(((64'd900  << (2 * FracBits)) + 64'd9999) / 64'd10000),
    SumW'(((64'd1600 << (2 * FracBits)) + 64'd9999) / 64'd10000),
    SumW'(((64'd1600 << (2 * FracBits)) + 64'd9999) / 64'd10000),
    SumW'(((64'd1600 << (2 * FracBits)) + 64'd9999) / 64'd10000)
  };

  // One axis after the subtract stage, with its division in flight.
  typedef struct packed {
    logic                zero;
    logic                neg;
    logic                sat;
    logic [AxisW-1:0]    span;
    logic [AxisW-1:0]    rem;
    logic [FracBits-1:0] quo;
  } axis_div_t;

  // Direction bits: up, down, left, right.
  typedef struct packed {
    logic rgt;
    logic lft;
    logic dn;
    logic up;
  } dir_t;

  function automatic axis_div_t axis_prep(input logic [AxisW-1:0] raw,
                                          input logic [AxisW-1:0] cen,
                                          input logic [AxisW-1:0] mn,
                                          input logic [AxisW-1:0] mx);
    axis_div_t         r;
    logic signed [AxisW:0] d;
    logic signed [AxisW:0] s;
    logic [AxisW-1:0]  ad;
    logic [AxisW-1:0]  as;
    d  = $signed({1'b0, raw}) - $signed({1'b0, cen});
    s  = d[AxisW] ? ($signed({1'b0, cen}) - $signed({1'b0, mn}))
                  : ($signed({1'b0, mx}) - $signed({1'b0, cen}));
    ad = d[AxisW] ? AxisW'(-d) : AxisW'(d);
    as = s[AxisW] ? AxisW'(-s) : AxisW'(s);
    r.zero = (d == '0);
    r.neg  = d[AxisW] ^ s[AxisW];
    r.sat  = (as == '0) || (ad >= as);
    r.span = as;
    r.rem  = ad;
    r.quo  = '0;
    return r;
  endfunction

  // One restoring division step: one quotient bit.
  function automatic axis_div_t div_step(input axis_div_t a);
    axis_div_t       r;
    logic [AxisW:0]  sh;
    r  = a;
    sh = {a.rem, 1'b0};
    if (sh >= {1'b0, a.span}) begin
      r.rem = AxisW'(sh - {1'b0, a.span});
      r.quo = {a.quo[FracBits-2:0], 1'b1};
    end else begin
      r.rem = sh[AxisW-1:0];
      r.quo = {a.quo[FracBits-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic signed [NormW-1:0] axis_value(input axis_div_t a);
    logic [NormW-1:0] mag;
    if (a.zero) begin
      mag = '0;
    end else if (a.sat) begin
      mag = NormW'(1) << FracBits;
    end else begin
      mag = {2'b00, a.quo};
    end
    return a.neg ? $signed(-mag) : $signed(mag);
  endfunction

  function automatic dir_t directions(input logic signed [NormW-1:0] x,
                                      input logic signed [NormW-1:0] y,
                                      input logic [SqW-1:0]         xx,
                                      input logic [SqW-1:0]         yy,
                                      input logic [1:0]             mode);
    dir_t        r;
    logic        xp;
    logic        yp;
    logic        yn;
    logic [SqW+1:0] xx3;
    logic [SqW+1:0] yy3;
    r   = '0;
    xp  = (x > 0);
    yp  = (y > 0);
    yn  = (y < 0);
    xx3 = (SqW+2)'(xx) + (SqW+2)'({xx, 1'b0});
    yy3 = (SqW+2)'(yy) + (SqW+2)'({yy, 1'b0});
    case (mode)
      Way2: begin
        if (x != 0) begin
          r.rgt = xp;
          r.lft = !xp;
        end else begin
          r.rgt = yp;
          r.lft = !yp;
        end
      end
      Way4: begin
        if (yy > xx) begin
          r.up = yp;
          r.dn = !yp;
        end else if (xx > yy) begin
          r.rgt = xp;
          r.lft = !xp;
        end else if (xp) begin
          r.rgt = yp;
          r.dn  = !yp;
        end else begin
          r.lft = yn;
          r.up  = !yn;
        end
      end
      default: begin
        if (xx3 < (SqW+2)'(yy)) begin
          r.up = yp;
          r.dn = !yp;
        end else if ((SqW+2)'(xx) > yy3) begin
          r.rgt = xp;
          r.lft = !xp;
        end else begin
          r.up  = yp;
          r.dn  = !yp;
          r.rgt = xp;
          r.lft = !xp;
        end
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/dual_stick_direction_decoder.sv
// Top level of the dual stick direction decoder: five-stage pipeline.
`default_nettype none
// The decoder takes one controller report per transaction on the slave stream and
// returns one result transaction, registered, on the master stream. A new
// report can be taken every cycle; the whole pipeline holds while the master side
// stalls and moves on as soon as the output register is empty or being taken.
// Behind the subtract stage, the per-axis divider spreads its quotient bits over
// two stages, followed by a squaring stage and a compare stage. The left stick is
// a 6-bit axis pair and the right stick a 5-bit pair, each normalized around its
// calibrated center to signed Q1.8 and saturated to plus or minus one. A stick
// counts only beyond the selected dead zone; inside it all its direction bits and
// the left analog values are zero. Configuration writes are always taken and must
// only be issued while no transaction is in flight.
module dual_stick_direction_decoder (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // report_byte0 [7:0], report_byte1 [15:8], report_byte2 [23:16], report_byte3 [31:24]
  input  wire logic [31:0]               s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // left_up, left_down, left_left, left_right, right_north, right_east,
  // right_south, right_west, left_active, left_x_norm [18:9], left_y_norm [28:19]
  output logic [31:0]                    m_axis_tdata,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [2:0]                cfg_index_i,
  input  wire logic [dsd_pkg::CfgW-1:0]  cfg_data_i
);
  import dsd_pkg::*;

  // Configuration registers.
  logic [17:0] lx_cal_q, ly_cal_q;
  logic [14:0] rx_cal_q, ry_cal_q;
  logic [2:0]  dz_sel_q;
  logic [1:0]  way_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_cal_q <= 18'd225630;
      ly_cal_q <= 18'd225630;
      rx_cal_q <= 15'd30735;
      ry_cal_q <= 15'd30735;
      dz_sel_q <= '0;
      way_q    <= Way8;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgLeftX:   lx_cal_q <= cfg_data_i[17:0];
        CfgLeftY:   ly_cal_q <= cfg_data_i[17:0];
        CfgRightX:  rx_cal_q <= cfg_data_i[14:0];
        CfgRightY:  ry_cal_q <= cfg_data_i[14:0];
        CfgDzSel:   dz_sel_q <= cfg_data_i[2:0];
        CfgWayMode: way_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together when the output register can take a result.
  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, vo_q;

  assign adv           = !vo_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      vo_q <= v4_q;
    end
  end

  // Stage 1: unpack the sticks, subtract the center and pick the span.
  logic [5:0] lx_raw, ly_raw;
  logic [4:0] rx_raw, ry_raw;
  axis_div_t  ax1_d [4];
  axis_div_t  ax1_q [4];

  assign lx_raw = s_axis_tdata[5:0];
  assign ly_raw = s_axis_tdata[13:8];
  assign rx_raw = {s_axis_tdata[7:6], s_axis_tdata[15:14], s_axis_tdata[23]};
  assign ry_raw = s_axis_tdata[20:16];

  always_comb begin
    ax1_d[0] = axis_prep(lx_raw, lx_cal_q[5:0], lx_cal_q[11:6], lx_cal_q[17:12]);
    ax1_d[1] = axis_prep(ly_raw, ly_cal_q[5:0], ly_cal_q[11:6], ly_cal_q[17:12]);
    ax1_d[2] = axis_prep({1'b0, rx_raw}, {1'b0, rx_cal_q[4:0]},
                         {1'b0, rx_cal_q[9:5]}, {1'b0, rx_cal_q[14:10]});
    ax1_d[3] = axis_prep({1'b0, ry_raw}, {1'b0, ry_cal_q[4:0]},
                         {1'b0, ry_cal_q[9:5]}, {1'b0, ry_cal_q[14:10]});
  end

  // Stages 2 and 3: the upper and then the lower quotient bits of |d| * 2^F / |span|.
  axis_div_t ax2_d [4];
  axis_div_t ax2_q [4];
  axis_div_t ax3_d [4];
  logic signed [NormW-1:0] val3_d [4];
  logic signed [NormW-1:0] val3_q [4];

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      ax2_d[a] = ax1_q[a];
      for (int s = 0; s < DivHi; s++) begin
        ax2_d[a] = div_step(ax2_d[a]);
      end
      ax3_d[a] = ax2_q[a];
      for (int s = 0; s < DivLo; s++) begin
        ax3_d[a] = div_step(ax3_d[a]);
      end
      val3_d[a] = axis_value(ax3_d[a]);
    end
  end

  // Stage 4: squares of every axis.
  logic signed [2*NormW-1:0] prod4 [4];
  logic [SqW-1:0]            sq4_q [4];
  logic signed [NormW-1:0]   val4_q [4];

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      prod4[a] = val3_q[a] * val3_q[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax1_q <= ax1_d;
      ax2_q <= ax2_d;
      val3_q <= val3_d;
      val4_q <= val3_q;
      for (int a = 0; a < 4; a++) begin
        sq4_q[a] <= prod4[a][SqW-1:0];
      end
    end
  end

  // Stage 5: dead zone compare and sector decode into the output register.
  logic [SumW-1:0] lsum, rsum;
  logic            l_act, r_act;
  dir_t            ldir, rdir;
  logic [31:0]     out_d;
  logic [31:0]     out_q;

  always_comb begin
    lsum  = SumW'(sq4_q[0]) + SumW'(sq4_q[1]);
    rsum  = SumW'(sq4_q[2]) + SumW'(sq4_q[3]);
    l_act = (lsum >= DzThresh[dz_sel_q]);
    r_act = (rsum >= DzThresh[dz_sel_q]);
    ldir  = directions(val4_q[0], val4_q[1], sq4_q[0], sq4_q[1], way_q);
    rdir  = directions(val4_q[2], val4_q[3], sq4_q[2], sq4_q[3], Way8);
    if (!l_act) ldir = '0;
    if (!r_act) rdir = '0;
    out_d        = '0;
    out_d[0]     = ldir.up;
    out_d[1]     = ldir.dn;
    out_d[2]     = ldir.lft;
    out_d[3]     = ldir.rgt;
    out_d[4]     = rdir.up;
    out_d[5]     = rdir.rgt;
    out_d[6]     = rdir.dn;
    out_d[7]     = rdir.lft;
    out_d[8]     = l_act;
    out_d[9 +: NormW]         = l_act ? val4_q[0] : '0;
    out_d[9 + NormW +: NormW] = l_act ? val4_q[1] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = out_q;

  // An idle left stick reports no direction and zero analog values.
  a_left_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[8]) |->
      (m_axis_tdata[3:0] == 4'b0 && m_axis_tdata[28:9] == '0))
    else $error("inactive left stick shows output");

  // Opposite directions never come together: left up and down, and both right pairs.
  a_no_opposite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]) &&
                      !(m_axis_tdata[4] && m_axis_tdata[6]) &&
                      !(m_axis_tdata[5] && m_axis_tdata[7]))
    else $error("opposite directions both set");

  // With every stage full, an accepted report leaves the output register valid.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && v1_q && v2_q && v3_q && v4_q) |=> vo_q)
    else $error("full pipeline lost a transaction");

endmodule
`default_nettype wire

FILE: tb/sv/dsd_scoreboard.sv
// Checker for the dual stick decoder: predicts each result and compares it.
`timescale 1ns / 1ps
module dsd_scoreboard (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid,
  input  wire logic                     s_axis_tready,
  input  wire logic [31:0]              s_axis_tdata,
  input  wire logic                     m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  input  wire logic [31:0]              m_axis_tdata,
  input  wire logic                     cfg_valid_i,
  input  wire logic                     cfg_ready_o,
  input  wire logic [2:0]               cfg_index_i,
  input  wire logic [dsd_pkg::CfgW-1:0] cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);
  import dsd_pkg::*;

  typedef struct packed {
    logic [9:0] ly;
    logic [9:0] lx;
    logic       act;
    logic       rw;
    logic       rs;
    logic       re;
    logic       rn;
    logic       lr;
    logic       ll;
    logic       ld;
    logic       lu;
  } decoded_t;

  logic [17:0] lx_cal, ly_cal;
  logic [14:0] rx_cal, ry_cal;
  logic [2:0]  dz_sel;
  logic [1:0]  way;
  decoded_t    expected_q[$];

  function automatic int scale_axis(int raw, logic [17:0] cal, int w);
    int m, c, mn, mx, d, s, ad, as, mag;
    m  = (1 << w) - 1;
    c  = cal & m;
    mn = (cal >> w) & m;
    mx = (cal >> (2 * w)) & m;
    d  = raw - c;
    if (d == 0) return 0;
    s   = (d > 0) ? mx - c : c - mn;
    ad  = d < 0 ? -d : d;
    as  = s < 0 ? -s : s;
    mag = (as == 0) ? 256 : (ad * 256) / as;
    if (mag > 256) mag = 256;
    return ((d < 0) != (s < 0)) ? -mag : mag;
  endfunction

  function automatic bit beyond_deadzone(int x, int y);
    longint k;
    longint sq;
    case (dz_sel)
      3'd0: k = 12;
      3'd1: k = 15;
      3'd2: k = 17;
      3'd3: k = 20;
      3'd4: k = 30;
      default: k = 40;
    endcase
    sq = longint'(x * x + y * y);
    return sq * 10000 >= ((k * k) << 16);
  endfunction

  // Returns {right, left, down, up}.
  function automatic logic [3:0] stick_dirs(int x, int y, logic [1:0] mode);
    longint xx, yy;
    logic [3:0] v, h;
    xx = longint'(x * x);
    yy = longint'(y * y);
    v  = (y > 0) ? 4'b0001 : 4'b0010;
    h  = (x > 0) ? 4'b1000 : 4'b0100;
    if (mode == Way2) begin
      if (x != 0) return h;
      return (y > 0) ? 4'b1000 : 4'b0100;
    end
    if (mode == Way4) begin
      if (yy > xx) return v;
      if (xx > yy) return h;
      if (x > 0) return (y > 0) ? 4'b1000 : 4'b0010;
      return (y < 0) ? 4'b0100 : 4'b0001;
    end
    if (3 * xx < yy) return v;
    if (xx > 3 * yy) return h;
    return v | h;
  endfunction

  function automatic decoded_t decode_report(logic [31:0] rep);
    decoded_t   r;
    int         lx, ly, rx, ry;
    logic [3:0] ldir, rdir;
    bit         la, ra;
    lx = scale_axis(int'(rep[5:0]), lx_cal, 6);
    ly = scale_axis(int'(rep[13:8]), ly_cal, 6);
    rx = scale_axis(int'({rep[7:6], rep[15:14], rep[23]}), {3'b0, rx_cal}, 5);
    ry = scale_axis(int'(rep[20:16]), {3'b0, ry_cal}, 5);
    la = beyond_deadzone(lx, ly);
    ra = beyond_deadzone(rx, ry);
    ldir = la ? stick_dirs(lx, ly, way) : 4'b0;
    rdir = ra ? stick_dirs(rx, ry, Way8) : 4'b0;
    r.lu = ldir[0]; r.ld = ldir[1]; r.ll = ldir[2]; r.lr = ldir[3];
    r.rn = rdir[0]; r.rs = rdir[1]; r.rw = rdir[2]; r.re = rdir[3];
    r.act = la;
    r.lx  = la ? 10'(lx) : 10'd0;
    r.ly  = la ? 10'(ly) : 10'd0;
    return r;
  endfunction

  task automatic compare_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      fail_count_o++;
    end
  endtask

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t e, g;
    if (!rst_ni) begin
      lx_cal <= 18'd225630;
      ly_cal <= 18'd225630;
      rx_cal <= 15'd30735;
      ry_cal <= 15'd30735;
      dz_sel <= '0;
      way <= Way8;
      expected_q.delete();
      fail_count_o = 0;
      checked_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgLeftX:   lx_cal <= cfg_data_i;
          CfgLeftY:   ly_cal <= cfg_data_i;
          CfgRightX:  rx_cal <= cfg_data_i[14:0];
          CfgRightY:  ry_cal <= cfg_data_i[14:0];
          CfgDzSel:   dz_sel <= cfg_data_i[2:0];
          CfgWayMode: way <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(decode_report(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        g = m_axis_tdata[28:0];
        if (expected_q.size() == 0) begin
          $error("result with no report pending");
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          checked_o++;
          compare_field("left_up", int'(e.lu), int'(g.lu));
          compare_field("left_down", int'(e.ld), int'(g.ld));
          compare_field("left_left", int'(e.ll), int'(g.ll));
          compare_field("left_right", int'(e.lr), int'(g.lr));
          compare_field("right_north", int'(e.rn), int'(g.rn));
          compare_field("right_east", int'(e.re), int'(g.re));
          compare_field("right_south", int'(e.rs), int'(g.rs));
          compare_field("right_west", int'(e.rw), int'(g.rw));
          compare_field("left_active", int'(e.act), int'(g.act));
          compare_field("left_x_norm", int'($signed(e.lx)), int'($signed(g.lx)));
          compare_field("left_y_norm", int'($signed(e.ly)), int'($signed(g.ly)));
          compare_field("tdata padding", 0, int'(m_axis_tdata[31:29]));
        end
      end
    end
  end
endmodule

FILE: tb/sv/tb_top.sv
// Stimulus and verdict for the dual stick direction decoder.
`timescale 1ns / 1ps
module tb_top;
  import dsd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  int          fail_count, pending, checked;
  int          send_idle_pct = 0, stall_pct = 0;
  bit          hold_off = 1'b0;
  int          sent = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  dual_stick_direction_decoder u_top (.*);

  dsd_scoreboard u_check (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // The receiver stalls at random, or for the whole of a long hold-off.
  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // Offers one report and waits for its transaction, idling at random first.
  // Valid stays high after the transaction so reports can follow back to back;
  // the idle cycles and drain() take it low.
  task automatic send_report(logic [31:0] rep);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rep;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Every report yields a result, so an empty queue means the pipe is idle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Random report over the whole range of every byte.
  function automatic logic [31:0] random_report();
    return $urandom();
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_report(random_report());
  endtask

  task automatic write_cal(logic [5:0] mx, logic [5:0] mn, logic [5:0] cn,
                           logic [4:0] rmx, logic [4:0] rmn, logic [4:0] rcn);
    write_reg(CfgLeftX, {mx, mn, cn});
    write_reg(CfgLeftY, {mx, mn, cn});
    write_reg(CfgRightX, CfgW'({rmx, rmn, rcn}));
    write_reg(CfgRightY, CfgW'({rmx, rmn, rcn}));
  endtask

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: centers, extremes of every byte, diagonals and ties.
    send_report({8'h00, 8'h0F, 8'hDE, 8'hDE});    // left and right y centered, right x top
    send_report(32'h0000_0000);
    send_report(32'hFFFF_FFFF);
    send_report({8'h00, 8'h8F, 8'h3F, 8'h1E});    // left up, right x near bottom
    send_report({8'h00, 8'h00, 8'h00, 8'h3F});
    send_report({8'h00, 8'h1F, 8'h05, 8'h37});
    send_report({8'h00, 8'h80, 8'hC0, 8'hC0});
    send_report({8'hA5, 8'h5A, 8'h55, 8'hAA});
    drain();
    // Ties on the diagonals in every way mode, and a zero span.
    write_cal(6'd40, 6'd20, 6'd30, 5'd20, 5'd10, 5'd15);
    for (int m = Way8; m <= 3; m++) begin
      write_reg(CfgWayMode, CfgW'(m));
      send_report({8'h00, 8'h0F, 8'h28, 8'h28});
      send_report({8'h00, 8'h0F, 8'h14, 8'h28});
      send_report({8'h00, 8'h0F, 8'h14, 8'h14});
      send_report({8'h00, 8'h0F, 8'h28, 8'h14});
      send_report({8'h00, 8'h0F, 8'h1E, 8'h28});
      drain();
    end
    write_cal(6'd30, 6'd30, 6'd30, 5'd15, 5'd15, 5'd15);
    send_report({8'h00, 8'h0F, 8'h1F, 8'h1D});
    send_report({8'h00, 8'h10, 8'h1E, 8'h1E});
    drain();

    // Random phases over several settings and idling mixes.
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 64; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      drain();
      case (ph % 4)
        0: write_cal(6'd55, 6'd5, 6'd30, 5'd30, 5'd0, 5'd15);
        1: write_cal(6'd63, 6'd0, 6'd31, 5'd31, 5'd0, 5'd16);
        2: write_cal(6'($urandom), 6'($urandom), 6'($urandom),
                     5'($urandom), 5'($urandom), 5'($urandom));
        default: write_cal(6'd0, 6'd63, 6'd63, 5'd0, 5'd31, 5'd0);
      endcase
      write_reg(CfgDzSel, CfgW'(ph % 8));
      write_reg(CfgWayMode, CfgW'(ph % 4));
      if (ph == 5) begin
        // Long receiver hold-off while reports keep coming, then a full pause.
        fork
          begin
            hold_off = 1'b1;
            repeat (200) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
        random_phase(40);
        drain();
      end
      random_phase(120);
    end
    drain();
    $display("Covered %0d reports, %0d results checked, all registers and idling mixes.",
             sent, checked);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
